FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the decompressor RTL.
// Expects clk and arst_n in the scope of the user; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_AR(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AR(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: rtl/core/ppd_pkg.sv
// Shared types, constants and the FCS-16 step for the Predictor-1 decompressor.
// No dependencies; the front, queue, back and top modules import it.
package ppd_pkg;

	localparam int HASH_BITS   = 16;
	localparam int MAX_OUT_LEN = 1600;
	localparam int TABLE_SIZE  = 1 << HASH_BITS;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [15:0] MAX_CNT  = 16'(MAX_OUT_LEN);
	localparam logic [15:0] FCS_INIT = 16'hFFFF;
	localparam logic [15:0] FCS_POLY = 16'h8408;
	localparam logic [15:0] FCS_GOOD = 16'hF0B8;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_LEN  = 2'd1,
		ST_FCS  = 2'd2,
		ST_RUNT = 2'd3
	} status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		PH_HDR0 = 2'd0,
		PH_HDR1 = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_RUN,
		S_GUESS,
		S_END,
		S_FCS,
		S_STAT
	} back_state_t;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic        hdr;   // header complete: load mode, length, header FCS
		logic        data;  // dat is a payload byte
		logic        eop;   // packet ends with this beat
		logic        runt;  // packet ended too short
		logic [7:0]  dat;
		logic [7:0]  fcs0;  // trailing bytes, oldest first
		logic [7:0]  fcs1;
		logic        mode;
		logic [14:0] len;
		logic [15:0] hfcs;
	} cmd_t;

	function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
		logic [15:0] f;
		f = fcs ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
		end
		return f;
	endfunction

endpackage

FILE: rtl/core/ppd_if.sv
// Valid/ready channel interfaces for packet bytes in and results out.
// No dependencies.
interface ppd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_packet;

	modport source (output valid, output in_byte, output end_of_packet, input ready);
	modport sink   (input valid, input in_byte, input end_of_packet, output ready);
endinterface

interface ppd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       result_kind;
	logic [1:0] status;
	logic       run_last;

	modport source (output valid, output out_byte, output result_kind, output status,
		output run_last, input ready);
	modport sink   (input valid, input out_byte, input result_kind, input status,
		input run_last, output ready);
endinterface

FILE: rtl/core/ppd_front.sv
// Front end: takes packet beats, splits header, payload and trailing FCS bytes.
// Uses ppd_pkg and ppd_in_if; feeds commands to ppd_cmd_queue.
module ppd_front (
	input  logic          clk,
	input  logic          arst_n,
	ppd_in_if.sink        pkt,
	input  logic          busy,
	input  logic          q_full,
	output logic          push,
	output ppd_pkg::cmd_t push_cmd
);
	import ppd_pkg::*;

	phase_t      phase_q;
	logic [1:0]  seen_q;
	logic [7:0]  hw0_q;
	logic [7:0]  hw1_q;
	logic        mode_q;
	logic [6:0]  lenhi_q;
	logic [15:0] hfcs_q;
	logic        accept;

	assign pkt.ready = !q_full && !busy;
	assign accept    = pkt.valid && pkt.ready;

	always_comb begin
		push_cmd      = '0;
		push_cmd.eop  = pkt.end_of_packet;
		push_cmd.dat  = hw0_q;
		push_cmd.fcs0 = seen_q[1] ? hw1_q : hw0_q;
		push_cmd.fcs1 = pkt.in_byte;
		push_cmd.mode = mode_q;
		push_cmd.len  = {lenhi_q, pkt.in_byte};
		push_cmd.hfcs = fcs_update(hfcs_q, pkt.in_byte);
		push          = 1'b0;
		unique case (phase_q)
			PH_HDR0: begin
				push_cmd.runt = 1'b1;
				push          = accept && pkt.end_of_packet;
			end
			PH_HDR1: begin
				push_cmd.runt = pkt.end_of_packet;
				push_cmd.hdr  = !pkt.end_of_packet;
				push          = accept;
			end
			default: begin
				// body: the oldest held byte leaves once the window is full
				push_cmd.data = seen_q[1];
				push_cmd.runt = (seen_q == 2'd0);
				push          = accept && (seen_q[1] || pkt.end_of_packet);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			seen_q  <= 2'd0;
		end else if (accept) begin
			if (pkt.end_of_packet) begin
				phase_q <= PH_HDR0;
				seen_q  <= 2'd0;
			end else begin
				unique case (phase_q)
					PH_HDR0: phase_q <= PH_HDR1;
					PH_HDR1: phase_q <= PH_BODY;
					default: begin
						if (!seen_q[1]) begin
							seen_q <= seen_q + 2'd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (phase_q)
				PH_HDR0: begin
					mode_q  <= pkt.in_byte[7];
					lenhi_q <= pkt.in_byte[6:0];
					hfcs_q  <= fcs_update(FCS_INIT, {1'b0, pkt.in_byte[6:0]});
				end
				PH_HDR1: begin
				end
				default: begin
					if (seen_q[1]) begin
						hw0_q <= hw1_q;
						hw1_q <= pkt.in_byte;
					end else if (seen_q[0]) begin
						hw1_q <= pkt.in_byte;
					end else begin
						hw0_q <= pkt.in_byte;
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/ppd_cmd_queue.sv
// Short command FIFO between the front end and the expansion engine.
// Uses ppd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppd_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ppd_pkg::cmd_t push_cmd,
	input  logic          pop,
	output ppd_pkg::cmd_t pop_cmd,
	output logic          full,
	output logic          empty
);
	import ppd_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	`ASSERT_NEVER(a_q_overrun, push && full, "command pushed into a full queue")
	`ASSERT_NEVER(a_q_underrun, pop && empty, "command popped from an empty queue")

endmodule

FILE: rtl/core/ppd_back.sv
// Expansion engine: guess table, hash, FCS check, output register.
// Uses ppd_pkg, ppd_out_if and assert_macros.svh; drains ppd_cmd_queue.
`include "assert_macros.svh"

module ppd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  ppd_pkg::cmd_t cmd,
	output logic          pop,
	output logic          busy,
	ppd_out_if.source     res
);
	import ppd_pkg::*;

	logic [7:0] gtab_mem [TABLE_SIZE];

	back_state_t          state_q, state_d;
	cmd_t                 cmd_q, cmd_d;
	logic [HASH_BITS-1:0] hash_q, hash_d;
	logic [HASH_BITS-1:0] clr_q, clr_d;
	logic [14:0]          len_q, len_d;
	logic                 mode_q, mode_d;
	logic [7:0]           flag_q, flag_d;
	logic [3:0]           bitpos_q, bitpos_d;
	logic [15:0]          fcs_q, fcs_d;
	logic [15:0]          count_q, count_d;
	logic                 ovf_q, ovf_d;
	status_t              status_q, status_d;
	logic [7:0]           rd_q;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q, out_byte_d;
	kind_t                out_kind_q, out_kind_d;
	status_t              out_status_q, out_status_d;
	logic                 out_last_q, out_last_d;
	logic                 out_load;
	logic                 slot_free;

	logic                 mem_we, mem_re;
	logic [HASH_BITS-1:0] mem_waddr;
	logic [7:0]           mem_wdata;

	logic                 put, put_last;
	logic [7:0]           put_byte;
	logic [3:0]           np;
	logic                 more;
	logic                 guess_last;

	function automatic logic [HASH_BITS-1:0] hash_step(input logic [HASH_BITS-1:0] h,
		input logic [7:0] b);
		logic [HASH_BITS+3:0] w;
		w = {h, 4'b0000} ^ (HASH_BITS + 4)'(b);
		return w[HASH_BITS-1:0];
	endfunction

	assign busy      = (state_q == S_CLEAR);
	assign slot_free = !out_valid_q || res.ready;

	assign res.valid       = out_valid_q;
	assign res.out_byte    = out_byte_q;
	assign res.result_kind = out_kind_q;
	assign res.status      = out_status_q;
	assign res.run_last    = out_last_q;

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		hash_d       = hash_q;
		clr_d        = clr_q;
		len_d        = len_q;
		mode_d       = mode_q;
		flag_d       = flag_q;
		bitpos_d     = bitpos_q;
		fcs_d        = fcs_q;
		count_d      = count_q;
		ovf_d        = ovf_q;
		status_d     = status_q;
		pop          = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = hash_q;
		mem_wdata    = cmd_q.dat;
		put          = 1'b0;
		put_byte     = cmd_q.dat;
		put_last     = 1'b0;
		out_load     = 1'b0;
		out_byte_d   = 8'h00;
		out_kind_d   = KIND_STATUS;
		out_status_d = status_q;
		out_last_d   = 1'b1;

		// does another guess follow the byte about to go out?
		np         = bitpos_q + 4'd1;
		more       = !np[3] && ((count_q + 16'd1) < MAX_CNT) && flag_q[np[2:0]];
		guess_last = !cmd_q.eop && !more;

		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'h00;
				clr_d     = clr_q + HASH_BITS'(1);
				if (&clr_q) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (cmd.hdr) begin
						mode_d = cmd.mode;
						len_d  = cmd.len;
						fcs_d  = cmd.hfcs;
					end else begin
						cmd_d   = cmd;
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (!cmd_q.data || ovf_q) begin
					state_d = S_END;
				end else if (mode_q) begin
					if (bitpos_q[3]) begin
						flag_d   = cmd_q.dat;
						bitpos_d = 4'd0;
						state_d  = S_RUN;
					end else if (slot_free) begin
						// literal: learn it and send it
						mem_we   = 1'b1;
						put      = 1'b1;
						put_last = guess_last;
						bitpos_d = np;
						state_d  = S_RUN;
					end
				end else if (count_q >= MAX_CNT) begin
					ovf_d   = 1'b1;
					state_d = S_END;
				end else if (slot_free) begin
					mem_we   = 1'b1;
					put      = 1'b1;
					put_last = !cmd_q.eop;
					state_d  = S_END;
				end
			end
			S_RUN: begin
				if (bitpos_q[3]) begin
					state_d = S_END;
				end else if (count_q >= MAX_CNT) begin
					ovf_d   = 1'b1;
					state_d = S_END;
				end else if (!flag_q[bitpos_q[2:0]]) begin
					state_d = S_END;
				end else begin
					mem_re  = 1'b1;
					state_d = S_GUESS;
				end
			end
			S_GUESS: begin
				if (slot_free) begin
					put      = 1'b1;
					put_byte = rd_q;
					put_last = guess_last;
					bitpos_d = np;
					state_d  = S_RUN;
				end
			end
			S_END: begin
				if (!cmd_q.eop) begin
					state_d = S_IDLE;
				end else if (cmd_q.runt) begin
					status_d = ST_RUNT;
					state_d  = S_STAT;
				end else if (ovf_q || (count_q != {1'b0, len_q})) begin
					status_d = ST_LEN;
					state_d  = S_STAT;
				end else begin
					fcs_d   = fcs_update(fcs_q, cmd_q.fcs0);
					state_d = S_FCS;
				end
			end
			S_FCS: begin
				status_d = (fcs_update(fcs_q, cmd_q.fcs1) == FCS_GOOD) ? ST_OK : ST_FCS;
				state_d  = S_STAT;
			end
			S_STAT: begin
				if (slot_free) begin
					out_load = 1'b1;
					len_d    = '0;
					mode_d   = 1'b0;
					flag_d   = 8'h00;
					bitpos_d = 4'd8;
					fcs_d    = FCS_INIT;
					count_d  = '0;
					ovf_d    = 1'b0;
					if (status_q != ST_OK) begin
						hash_d  = '0;
						clr_d   = '0;
						state_d = S_CLEAR;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
		endcase

		if (put) begin
			fcs_d        = fcs_update(fcs_q, put_byte);
			hash_d       = hash_step(hash_q, put_byte);
			count_d      = count_q + 16'd1;
			out_load     = 1'b1;
			out_byte_d   = put_byte;
			out_kind_d   = KIND_DATA;
			out_status_d = ST_OK;
			out_last_d   = put_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hash_q      <= '0;
			len_q       <= '0;
			mode_q      <= 1'b0;
			flag_q      <= 8'h00;
			bitpos_q    <= 4'd8;
			fcs_q       <= FCS_INIT;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			hash_q   <= hash_d;
			len_q    <= len_d;
			mode_q   <= mode_d;
			flag_q   <= flag_d;
			bitpos_q <= bitpos_d;
			fcs_q    <= fcs_d;
			count_q  <= count_d;
			ovf_q    <= ovf_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		status_q <= status_d;
		if (out_load) begin
			out_byte_q   <= out_byte_d;
			out_kind_q   <= out_kind_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	// guess table: one write port, one registered read port at the hash
	always_ff @(posedge clk) begin
		if (mem_we) begin
			gtab_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= gtab_mem[hash_q];
		end
	end

	`ASSERT_AR(a_count_bound, (count_q <= MAX_CNT), "output count passed the maximum")
	`ASSERT_AR(a_no_data_after_ovf, (put |-> !ovf_q), "data byte sent after overflow")
	`ASSERT_AR(a_err_clears, (out_load && out_kind_d == KIND_STATUS && out_status_d != ST_OK) |=> (state_q == S_CLEAR && hash_q == '0), "error status did not start a table clear")

endmodule

FILE: rtl/core/predictor1_packet_decompressor.sv
// Predictor-1 (PPP) packet decompressor, receive side: top level.
// Uses ppd_pkg, ppd_if, ppd_front, ppd_cmd_queue and ppd_back.
//
// Feed one packet byte per beat on pkt, end_of_packet on the last byte; the
// decompressed bytes come out on res followed by one status beat per packet,
// with run_last on the final result caused by each input beat. The front end
// takes header bytes and holds the first two body bytes, and hands work
// through a two-entry queue to the expansion engine; pkt.ready is low while
// the queue is full or the table is being cleared. In the engine each guess
// reads the table at the hash left by the byte before it, through the
// registered read port. At end of packet a runt or length status goes from
// the end state straight to the status state; a packet of good length passes
// through the FCS check state first.
// After reset and after any error status the guess table is cleared one entry
// per cycle, all 2**HASH_BITS entries, with pkt.ready held low.
module predictor1_packet_decompressor (
	input  logic       clk,
	input  logic       arst_n,
	ppd_in_if.sink     pkt,
	ppd_out_if.source  res
);
	import ppd_pkg::*;

	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	logic busy;

	ppd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt      (pkt),
		.busy     (busy),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ppd_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	ppd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.cmd    (pop_cmd),
		.pop    (pop),
		.busy   (busy),
		.res    (res)
	);

endmodule
